/* rtl/nske_pkg.sv */
// ----------------------------------------------------------------------------
// nske_pkg
// Shared constants and types for the natural sort key encoder.
// ----------------------------------------------------------------------------
package nske_pkg;

  // Default sizing
  localparam int MAX_RUN_DEF    = 56;
  localparam int WORD_BYTES_DEF = 4;

  // Character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] KEY_NUL   = 8'h00;

  // One key byte offered by the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] key_byte;
    logic       last_of_item;
    logic       end_of_key;
    logic       run_overflow;
  } emit_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  endfunction

endpackage

/* rtl/nske_if.sv */
// ----------------------------------------------------------------------------
// nske_if
// Valid/ready channels for string characters and encoded key bytes.
// ----------------------------------------------------------------------------
interface nske_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source (output valid, character, end_of_string, input ready);
  modport sink   (input valid, character, end_of_string, output ready);
endinterface

interface nske_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_of_item;
  logic       end_of_key;
  logic       run_overflow;

  modport source (output valid, key_byte, last_of_item, end_of_key, run_overflow,
                  input ready);
  modport sink   (input valid, key_byte, last_of_item, end_of_key, run_overflow,
                  output ready);
endinterface

/* rtl/natural_sort_key_encoder.sv */
// ----------------------------------------------------------------------------
// natural_sort_key_encoder
// Encodes string characters into a byte key with natural (numeric) ordering.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                         handshake
//   in_ch     in   character[8], end_of_string                     valid/ready
//   out_ch    out  key_byte[8], last_of_item, end_of_key,          valid/ready
//                  run_overflow
//
// A digit that does not end the string is only buffered (flagged once the
// run RAM is full). Any other character is accepted and emitted as bytes:
// a flushed run (marker, length, digits read from the run RAM at one per
// cycle while out_ch does not stall), then a non-digit, then any padding.
// Synchronous active-low reset; no clearing pass. Back-pressure on out_ch
// holds the sequencer, which drops in_ch.ready until the item is done.
// ----------------------------------------------------------------------------
module natural_sort_key_encoder #(
  parameter int MAX_RUN    = nske_pkg::MAX_RUN_DEF,
  parameter int WORD_BYTES = nske_pkg::WORD_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  nske_in_if.sink    in_ch,
  nske_out_if.source out_ch
);
  import nske_pkg::*;

  emit_t      emit;
  logic       slot_free;
  logic       out_valid_r;
  logic [7:0] key_byte_r;
  logic       last_r;
  logic       end_r;
  logic       ovf_r;

  nske_ctl #(
    .MAX_RUN    (MAX_RUN),
    .WORD_BYTES (WORD_BYTES)
  ) u_ctl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_character     (in_ch.character),
    .in_end_of_string (in_ch.end_of_string),
    .slot_free        (slot_free),
    .emit             (emit)
  );

  // Output register: loads whenever empty or being drained
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit.valid;
    end
    if (slot_free && emit.valid) begin
      key_byte_r <= emit.key_byte;
      last_r     <= emit.last_of_item;
      end_r      <= emit.end_of_key;
      ovf_r      <= emit.run_overflow;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_byte     = key_byte_r;
  assign out_ch.last_of_item = last_r;
  assign out_ch.end_of_key   = end_r;
  assign out_ch.run_overflow = ovf_r;

  // A non-digit always produces bytes, so the next cycle cannot take input
  a_nondigit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !is_digit(in_ch.character) |=> !in_ch.ready)
    else $error("input taken while a pass-through byte is pending");

  // End of key closes the item
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_key |-> out_ch.last_of_item)
    else $error("end_of_key without last_of_item");

  // A pass-through character closing a mid-string item never carries overflow
  a_char_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_item && !out_ch.end_of_key |-> !out_ch.run_overflow)
    else $error("overflow flag on a pass-through byte");

  // Nothing is offered to the output while the sequencer waits for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !emit.valid)
    else $error("byte emitted while accepting input");

endmodule

/* rtl/nske_ram.sv */
// ----------------------------------------------------------------------------
// nske_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nske_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 56
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nske_ctl.sv */
// ----------------------------------------------------------------------------
// nske_ctl
// Run tracking and byte sequencer: buffers digits in the run RAM and replays
// them as marker, length and digit bytes, then pass-through and padding.
// ----------------------------------------------------------------------------
module nske_ctl #(
  parameter int MAX_RUN    = 56,
  parameter int WORD_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_character,
  input  logic           in_end_of_string,
  input  logic           slot_free,
  output nske_pkg::emit_t emit
);
  import nske_pkg::*;

  localparam int LEN_W = $clog2(MAX_RUN + 1);
  localparam int AW    = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int BMW_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_LEN, ST_DIG, ST_CHAR, ST_PAD
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic             lead_zero_r, lead_zero_nxt;
  logic             ovf_r, ovf_nxt;
  logic [BMW_W-1:0] bmw_r, bmw_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             eos_r, eos_nxt;
  logic             pend_char_r, pend_char_nxt;

  logic [LEN_W-1:0] idx_inc;
  logic [BMW_W-1:0] bmw_inc;
  logic             in_dig;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  // Digit store; written at accept, read back only after the marker byte,
  // so a write and a read of the same entry never overlap
  nske_ram #(
    .WIDTH (8),
    .DEPTH (MAX_RUN)
  ) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (run_len_r[AW-1:0]),
    .wdata (in_character),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_dig   = is_digit(in_character);
  assign idx_inc  = idx_r + 1'b1;
  assign bmw_inc  = (bmw_r == BMW_W'(WORD_BYTES - 1)) ? '0 : bmw_r + 1'b1;

  // Sequencer next state and byte selection
  always_comb begin
    state_nxt     = state_r;
    run_len_nxt   = run_len_r;
    lead_zero_nxt = lead_zero_r;
    ovf_nxt       = ovf_r;
    bmw_nxt       = bmw_r;
    idx_nxt       = idx_r;
    char_nxt      = char_r;
    eos_nxt       = eos_r;
    pend_char_nxt = pend_char_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    emit          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          char_nxt      = in_character;
          eos_nxt       = in_end_of_string;
          pend_char_nxt = !in_dig;
          if (in_dig) begin
            if (run_len_r == '0) begin
              lead_zero_nxt = (in_character == CHAR_ZERO);
            end
            if (run_len_r < LEN_W'(MAX_RUN)) begin
              ram_we      = 1'b1;
              run_len_nxt = run_len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_end_of_string) begin
              state_nxt = ST_MARK;
            end
          end else begin
            state_nxt = (run_len_r != '0) ? ST_MARK : ST_CHAR;
          end
        end
      end

      ST_MARK: begin
        if (slot_free) begin
          emit.valid        = 1'b1;
          emit.key_byte     = KEY_NUL;
          emit.run_overflow = ovf_r;
          bmw_nxt           = bmw_inc;
          state_nxt         = ST_LEN;
        end
      end

      // Length byte; prefetch the first digit
      ST_LEN: begin
        if (slot_free) begin
          emit.valid        = 1'b1;
          emit.key_byte     = lead_zero_r ? KEY_NUL : 8'(run_len_r);
          emit.run_overflow = ovf_r;
          bmw_nxt           = bmw_inc;
          ram_re            = 1'b1;
          ram_raddr         = '0;
          idx_nxt           = '0;
          state_nxt         = ST_DIG;
        end
      end

      // Replay digits, fetching the next one as each is handed over
      ST_DIG: begin
        if (slot_free) begin
          emit.valid        = 1'b1;
          emit.key_byte     = ram_rdata;
          emit.run_overflow = ovf_r;
          bmw_nxt           = bmw_inc;
          if (idx_inc == run_len_r) begin
            run_len_nxt   = '0;
            lead_zero_nxt = 1'b0;
            ovf_nxt       = 1'b0;
            if (pend_char_r) begin
              state_nxt = ST_CHAR;
            end else if (bmw_inc == '0) begin
              emit.last_of_item = 1'b1;
              emit.end_of_key   = 1'b1;
              state_nxt         = ST_IDLE;
            end else begin
              state_nxt = ST_PAD;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
            idx_nxt   = idx_inc;
          end
        end
      end

      ST_CHAR: begin
        if (slot_free) begin
          emit.valid    = 1'b1;
          emit.key_byte = char_r;
          bmw_nxt       = bmw_inc;
          if (!eos_r) begin
            emit.last_of_item = 1'b1;
            state_nxt         = ST_IDLE;
          end else if (bmw_inc == '0) begin
            emit.last_of_item = 1'b1;
            emit.end_of_key   = 1'b1;
            state_nxt         = ST_IDLE;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        if (slot_free) begin
          emit.valid    = 1'b1;
          emit.key_byte = KEY_NUL;
          bmw_nxt       = bmw_inc;
          if (bmw_inc == '0) begin
            emit.last_of_item = 1'b1;
            emit.end_of_key   = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and run registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_len_r   <= '0;
      lead_zero_r <= 1'b0;
      ovf_r       <= 1'b0;
      bmw_r       <= '0;
      pend_char_r <= 1'b0;
      eos_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_len_r   <= run_len_nxt;
      lead_zero_r <= lead_zero_nxt;
      ovf_r       <= ovf_nxt;
      bmw_r       <= bmw_nxt;
      pend_char_r <= pend_char_nxt;
      eos_r       <= eos_nxt;
    end
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
  end

endmodule

/* tb/natural_sort_key_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natural_sort_key_encoder_test
// Drives strings into the natural sort key encoder with random gaps on the
// character side and random stalls on the key side. A local model of the
// encoder predicts every key byte. A checker compares each key byte with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module natural_sort_key_encoder_test;
  import nske_pkg::*;

  localparam int MAX_RUN      = MAX_RUN_DEF;
  localparam int WORD_BYTES   = WORD_BYTES_DEF;
  localparam int RANDOM_CHARS = 125;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 2000000;

  // One predicted key byte
  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_of_item;
    logic       end_of_key;
    logic       run_overflow;
  } key_byte_t;

  logic clk;
  logic rst_n;

  nske_in_if  in_ch ();
  nske_out_if out_ch ();

  natural_sort_key_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Encoder model state
  logic [7:0] run_digits [MAX_RUN];
  int         run_len;
  logic       run_zero_lead;
  logic       run_dropped;
  int         key_phase;
  key_byte_t  item_bytes [$];
  key_byte_t  key_bytes_due [$];

  // Run bookkeeping
  bit          idle_on = 1'b1;
  int          fail_count;
  int          chars_sent;
  int          strings_sent;
  int          bytes_checked;
  int          overflow_runs;
  int          sink_stall;
  int unsigned cycle_count;
  key_byte_t   want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length shared by both sides: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Key prediction
  // ---------------------------------------------------------------------------
  function automatic void emit_key_byte(logic [7:0] b, logic ovf);
    key_byte_t kb;
    kb.key_byte     = b;
    kb.last_of_item = 1'b0;
    kb.end_of_key   = 1'b0;
    kb.run_overflow = ovf;
    item_bytes.push_back(kb);
    key_phase = (key_phase + 1) % WORD_BYTES;
  endfunction

  // Marker, length (zero for a leading-zero run), then the kept digits
  function automatic void flush_digit_run();
    if (run_len != 0) begin
      if (run_dropped) overflow_runs++;
      emit_key_byte(KEY_NUL, run_dropped);
      emit_key_byte(run_zero_lead ? KEY_NUL : run_len[7:0], run_dropped);
      for (int i = 0; i < run_len; i++)
        emit_key_byte(run_digits[i], run_dropped);
      run_len       = 0;
      run_zero_lead = 1'b0;
      run_dropped   = 1'b0;
    end
  endfunction

  function automatic void predict_key_bytes(logic [7:0] ch, logic eos);
    logic numeric;
    numeric = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    item_bytes.delete();
    if (numeric) begin
      if (run_len == 0) run_zero_lead = (ch == CHAR_ZERO);
      // digits past the buffer are dropped and flagged
      if (run_len < MAX_RUN) begin
        run_digits[run_len] = ch;
        run_len++;
      end else begin
        run_dropped = 1'b1;
      end
      if (eos) flush_digit_run();
    end else begin
      flush_digit_run();
      emit_key_byte(ch, 1'b0);
    end
    // end of string: pad to a word boundary and start a fresh key
    if (eos) begin
      while (key_phase != 0) emit_key_byte(KEY_NUL, 1'b0);
      if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].end_of_key = 1'b1;
      run_len       = 0;
      run_zero_lead = 1'b0;
      run_dropped   = 1'b0;
      key_phase     = 0;
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last_of_item = 1'b1;
    foreach (item_bytes[i]) key_bytes_due.push_back(item_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.character     <= ch;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_key_bytes(ch, eos);
    chars_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eos_last && (i == s.len() - 1));
  endtask

  task automatic send_digit_run(input int len, input bit lead_zero, input logic eos_last);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if (i == 0)
        d = lead_zero ? CHAR_ZERO : 8'($urandom_range(CHAR_ZERO + 1, CHAR_NINE));
      else
        d = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      send_char(d, eos_last && (i == len - 1));
    end
  endtask

  // Letters, or any byte in range when any_byte is set (digits may appear)
  task automatic send_word(input int len, input bit any_byte, input logic eos_last);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if (any_byte) begin
        ch = 8'($urandom_range(1, 255));
      end else begin
        ch = 8'($urandom_range(8'h61, 8'h7A));
        if ($urandom_range(0, 1) == 1) ch = ch - 8'h20;
      end
      send_char(ch, eos_last && (i == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Key side: random stalls, and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= 0;
    end else if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else begin
      sink_stall   <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: key byte %0d %s mismatch: expected %h, actual %h",
               $time, bytes_checked, field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ($isunknown(out_ch.valid)) begin
        $display("%0t: out_valid is unknown", $time);
        fail_count++;
      end else if (out_ch.valid && out_ch.ready) begin
        if (key_bytes_due.size() == 0) begin
          $display("%0t: unexpected key byte: expected none, actual %h",
                   $time, out_ch.key_byte);
          fail_count++;
        end else begin
          want = key_bytes_due.pop_front();
          check_field("key_byte", want.key_byte, out_ch.key_byte);
          check_field("last_of_item", {7'd0, want.last_of_item}, {7'd0, out_ch.last_of_item});
          check_field("end_of_key", {7'd0, want.end_of_key}, {7'd0, out_ch.end_of_key});
          check_field("run_overflow", {7'd0, want.run_overflow}, {7'd0, out_ch.run_overflow});
          bytes_checked++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d key bytes outstanding",
               $time, cycle_count, key_bytes_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pass-through bytes, byte extremes, neighbors of the digit range, padding
  task automatic test_plain_text();
    send_text("A", 1'b1);
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("/:", 1'b1);
  endtask

  // Short runs: single digit at end of string, run between letters,
  // leading-zero runs ended by a letter and by the end of the string
  task automatic test_digit_runs();
    send_text("7", 1'b1);
    send_text("x12y", 1'b1);
    send_text("007", 1'b1);
    send_text("0a", 1'b1);
    send_text("9:", 1'b1);
    send_text("b0", 1'b1);
  endtask

  // Runs at and past the digit buffer, ended by a letter and by end of string
  task automatic test_long_runs();
    send_digit_run(MAX_RUN, 1'b0, 1'b0);
    send_char("k", 1'b0);
    send_digit_run(MAX_RUN + $urandom_range(1, 4), 1'b1, 1'b0);
    send_char(".", 1'b0);
    send_char("z", 1'b1);
    send_digit_run(MAX_RUN + $urandom_range(1, 6), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Random strings of letter words, digit runs and arbitrary bytes;
  // every third stretch of eight strings runs with no idling on either side
  task automatic test_random_strings();
    int target;
    int segs;
    int kind;
    int len;
    int n;
    bit last;
    target = chars_sent + RANDOM_CHARS;
    n      = 0;
    while (chars_sent < target) begin
      idle_on = ((n / 8) % 3 != 1);
      segs    = $urandom_range(1, 5);
      for (int seg = 0; seg < segs; seg++) begin
        last = (seg == segs - 1);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          len = ($urandom_range(0, 99) < 3) ? $urandom_range(40, MAX_RUN + 4)
                                            : $urandom_range(1, 6);
          send_digit_run(len, $urandom_range(0, 3) == 0, last);
        end else if (kind < 90) begin
          send_word($urandom_range(1, 4), 1'b0, last);
        end else begin
          send_word($urandom_range(1, 3), 1'b1, last);
        end
      end
      n++;
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    run_len             = 0;
    run_zero_lead       = 1'b0;
    run_dropped         = 1'b0;
    key_phase           = 0;
    in_ch.valid         <= 1'b0;
    in_ch.character     <= 8'h41;
    in_ch.end_of_string <= 1'b0;
    rst_n               <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_text();
    test_digit_runs();
    test_long_runs();
    test_random_strings();
    in_ch.valid <= 1'b0;

    // let every predicted key byte arrive, then watch for strays
    while (key_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d strings; checked %0d key bytes",
             chars_sent, strings_sent, bytes_checked);
    $display("Flushed %0d digit runs that overflowed the buffer; %0d mismatches",
             overflow_runs, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* natural_sort_key_encoder.f */
rtl/nske_pkg.sv
rtl/nske_if.sv
rtl/nske_ram.sv
rtl/nske_ctl.sv
rtl/natural_sort_key_encoder.sv
tb/natural_sort_key_encoder_test.sv
